>>> rtl/oqa_pkg.sv
`timescale 1ns / 1ps

package oqa_pkg;

    localparam int CORDIC_ITERS = 20;
    localparam int ITER_W = 5;

    // CORDIC datapath width: x and y stay below about 1.65 * 2^30, and z reaches
    // about 2^28 before the half-angle fold, so 34 bits hold them.
    localparam int CW = 34;
    // Width of the exact Hamilton and matrix sums. Two doubled matrix products of
    // full-scale entries reach 2^35, so one more bit than that is kept.
    localparam int SW = 37;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] DEG90 = 34'sd94371840;
    localparam logic signed [CW-1:0] DEG180 = 34'sd188743680;
    localparam logic signed [31:0] ONE_Q29 = 32'sd536870912;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_DELTA,
        ST_HAM,
        ST_MAT,
        ST_OUT
    } state_t;

    // Arctangent of 2^-i in degrees, Q.20.
    function automatic logic signed [CW-1:0] atan_q20(input logic [ITER_W-1:0] i);
        logic signed [CW-1:0] r;
        begin
            case (i)
                5'd0: r = 34'sd47185920;
                5'd1: r = 34'sd27855475;
                5'd2: r = 34'sd14718068;
                5'd3: r = 34'sd7471121;
                5'd4: r = 34'sd3750058;
                5'd5: r = 34'sd1876857;
                5'd6: r = 34'sd938658;
                5'd7: r = 34'sd469357;
                5'd8: r = 34'sd234682;
                5'd9: r = 34'sd117342;
                5'd10: r = 34'sd58671;
                5'd11: r = 34'sd29335;
                5'd12: r = 34'sd14668;
                5'd13: r = 34'sd7334;
                5'd14: r = 34'sd3667;
                5'd15: r = 34'sd1833;
                5'd16: r = 34'sd917;
                5'd17: r = 34'sd458;
                5'd18: r = 34'sd229;
                5'd19: r = 34'sd115;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> rtl/oqa_cordic.sv
`timescale 1ns / 1ps

// Three rotation-mode CORDIC lanes that share one step counter. All three half
// angles iterate together, one micro-rotation per cycle.
module oqa_cordic import oqa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [15:0]   ang_deg [3],
    output logic                 done,
    output logic signed [CW-1:0] cos_out [3],
    output logic signed [CW-1:0] sin_out [3]
);

    logic signed [CW-1:0] x_reg [3];
    logic signed [CW-1:0] y_reg [3];
    logic signed [CW-1:0] z_reg [3];
    logic [2:0] flip_reg;
    logic [ITER_W-1:0] iter_reg;
    logic busy_reg;

    // Iteration counter and busy flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            iter_reg <= '0;
        end else if (busy_reg) begin
            iter_reg <= iter_reg + 1'b1;
            if (iter_reg == ITER_W'(CORDIC_ITERS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign done = busy_reg && (iter_reg == ITER_W'(CORDIC_ITERS - 1));

    // Lane datapath: fold the half angle into +-90 degrees, then rotate.
    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic signed [CW-1:0] z0;
        assign z0 = CW'(ang_deg[g]) <<< 13;
        always_ff @(posedge aclk) begin
            if (start) begin
                x_reg[g] <= CORDIC_GAIN;
                y_reg[g] <= '0;
                if (z0 > DEG90) begin
                    z_reg[g] <= z0 - DEG180;
                    flip_reg[g] <= 1'b1;
                end else if (z0 < -DEG90) begin
                    z_reg[g] <= z0 + DEG180;
                    flip_reg[g] <= 1'b1;
                end else begin
                    z_reg[g] <= z0;
                    flip_reg[g] <= 1'b0;
                end
            end else if (busy_reg) begin
                if (!z_reg[g][CW-1]) begin
                    x_reg[g] <= x_reg[g] - (y_reg[g] >>> iter_reg);
                    y_reg[g] <= y_reg[g] + (x_reg[g] >>> iter_reg);
                    z_reg[g] <= z_reg[g] - atan_q20(iter_reg);
                end else begin
                    x_reg[g] <= x_reg[g] + (y_reg[g] >>> iter_reg);
                    y_reg[g] <= y_reg[g] - (x_reg[g] >>> iter_reg);
                    z_reg[g] <= z_reg[g] + atan_q20(iter_reg);
                end
            end
        end
        assign cos_out[g] = flip_reg[g] ? -x_reg[g] : x_reg[g];
        assign sin_out[g] = flip_reg[g] ? -y_reg[g] : y_reg[g];
    end

endmodule

>>> rtl/orientation_quaternion_accumulator_top.sv
`timescale 1ns / 1ps

// Channel | Direction | Ports                     | tdata fields, lowest bit first
// s_      | in        | s_tvalid s_tready s_tdata | roll_deg, pitch_deg, yaw_deg
// m_      | out       | m_tvalid m_tready m_tdata | row0_col0 .. row2_col2 (18 b each)
//
// A request runs from acceptance to a valid result through 20 CORDIC
// micro-rotations, then 46 steps of the single shared 34x34 multiplier
// (12 for the delta quaternion, 16 for the Hamilton product, 18 for the matrix).
// The next request is taken at the earliest in the cycle after the result
// handshake. s_tready is high only in idle; a stalled m_ channel holds the
// result and the block stays busy until it is taken.
// Reset restores the identity.
module orientation_quaternion_accumulator_top import oqa_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // roll_deg, pitch_deg, yaw_deg
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata    // row0_col0 .. row2_col2, 18 bits each, 6 zero bits on top
);

    state_t state_reg, state_next;
    logic [5:0] step_reg, step_next;

    logic signed [31:0] q_reg [4];
    logic signed [CW-1:0] d_reg [4];     // delta quaternion
    logic signed [CW-1:0] t_reg [4];     // crcp, srsp, srcp, crsp
    logic signed [SW-1:0] acc_reg;
    logic signed [31:0] nq_reg [4];
    logic [17:0] out_reg [9];

    logic cordic_start, cordic_done;
    logic signed [15:0] ang [3];
    logic signed [CW-1:0] cs [3];
    logic signed [CW-1:0] sn [3];

    assign ang[0] = s_tdata[15:0];
    assign ang[1] = s_tdata[31:16];
    assign ang[2] = s_tdata[47:32];

    oqa_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .ang_deg (ang),
        .done    (cordic_done),
        .cos_out (cs),
        .sin_out (sn)
    );

    // Scalar and negated vector part of the stored quaternion for the matrix.
    logic signed [CW-1:0] s_op, am_op, bm_op, cm_op;
    assign s_op = CW'(q_reg[0]);
    assign am_op = -CW'(q_reg[1]);
    assign bm_op = -CW'(q_reg[2]);
    assign cm_op = -CW'(q_reg[3]);

    // Operand selection for the shared multiplier, with shift and sign of the term.
    logic signed [CW-1:0] op_a, op_b;
    logic neg_term, sh29, last_term, first_term;
    logic [3:0] dst;

    always_comb begin
        op_a = '0;
        op_b = '0;
        neg_term = 1'b0;
        sh29 = 1'b0;
        first_term = 1'b0;
        last_term = 1'b0;
        dst = '0;
        unique case (state_reg)
            ST_DELTA: begin
                case (step_reg)
                    6'd0: begin op_a = cs[0]; op_b = cs[1]; first_term = 1'b1; end
                    6'd1: begin op_a = sn[0]; op_b = sn[1]; first_term = 1'b1; end
                    6'd2: begin op_a = sn[0]; op_b = cs[1]; first_term = 1'b1; end
                    6'd3: begin op_a = cs[0]; op_b = sn[1]; first_term = 1'b1; end
                    6'd4: begin op_a = t_reg[0]; op_b = cs[2]; first_term = 1'b1; end
                    6'd5: begin op_a = t_reg[1]; op_b = sn[2]; last_term = 1'b1; end
                    6'd6: begin op_a = t_reg[2]; op_b = cs[2]; first_term = 1'b1; end
                    6'd7: begin op_a = t_reg[3]; op_b = sn[2]; neg_term = 1'b1;
                        last_term = 1'b1; end
                    6'd8: begin op_a = t_reg[3]; op_b = cs[2]; first_term = 1'b1; end
                    6'd9: begin op_a = t_reg[2]; op_b = sn[2]; last_term = 1'b1; end
                    6'd10: begin op_a = t_reg[0]; op_b = sn[2]; first_term = 1'b1; end
                    6'd11: begin op_a = t_reg[1]; op_b = cs[2]; neg_term = 1'b1;
                        last_term = 1'b1; end
                    default: ;
                endcase
                dst = 4'(step_reg);
            end
            ST_HAM: begin
                // Row r uses q[k] times d[sel] with sign from the Hamilton table.
                first_term = (step_reg[1:0] == 2'd0);
                last_term = (step_reg[1:0] == 2'd3);
                op_a = CW'(q_reg[step_reg[1:0]]);
                case (step_reg[3:0])
                    4'd0: op_b = d_reg[0];
                    4'd1: begin op_b = d_reg[1]; neg_term = 1'b1; end
                    4'd2: begin op_b = d_reg[2]; neg_term = 1'b1; end
                    4'd3: begin op_b = d_reg[3]; neg_term = 1'b1; end
                    4'd4: op_b = d_reg[1];
                    4'd5: op_b = d_reg[0];
                    4'd6: op_b = d_reg[3];
                    4'd7: begin op_b = d_reg[2]; neg_term = 1'b1; end
                    4'd8: op_b = d_reg[2];
                    4'd9: begin op_b = d_reg[3]; neg_term = 1'b1; end
                    4'd10: op_b = d_reg[0];
                    4'd11: op_b = d_reg[1];
                    4'd12: op_b = d_reg[3];
                    4'd13: op_b = d_reg[2];
                    4'd14: begin op_b = d_reg[1]; neg_term = 1'b1; end
                    4'd15: op_b = d_reg[0];
                    default: ;
                endcase
                dst = {2'b00, step_reg[3:2]};
            end
            ST_MAT: begin
                // Two terms per entry, row-major. The vector part is negated before
                // each product so that the floor shift sees the conjugate's values.
                sh29 = 1'b1;
                first_term = !step_reg[0];
                last_term = step_reg[0];
                dst = 4'(step_reg >> 1);
                case (step_reg)
                    6'd0: begin op_a = bm_op; op_b = bm_op; neg_term = 1'b1; end
                    6'd1: begin op_a = cm_op; op_b = cm_op; neg_term = 1'b1; end
                    6'd2: begin op_a = am_op; op_b = bm_op; end
                    6'd3: begin op_a = cm_op; op_b = s_op; neg_term = 1'b1; end
                    6'd4: begin op_a = am_op; op_b = cm_op; end
                    6'd5: begin op_a = bm_op; op_b = s_op; end
                    6'd6: begin op_a = am_op; op_b = bm_op; end
                    6'd7: begin op_a = cm_op; op_b = s_op; end
                    6'd8: begin op_a = am_op; op_b = am_op; neg_term = 1'b1; end
                    6'd9: begin op_a = cm_op; op_b = cm_op; neg_term = 1'b1; end
                    6'd10: begin op_a = bm_op; op_b = cm_op; end
                    6'd11: begin op_a = am_op; op_b = s_op; neg_term = 1'b1; end
                    6'd12: begin op_a = am_op; op_b = cm_op; end
                    6'd13: begin op_a = bm_op; op_b = s_op; neg_term = 1'b1; end
                    6'd14: begin op_a = bm_op; op_b = cm_op; end
                    6'd15: begin op_a = am_op; op_b = s_op; end
                    6'd16: begin op_a = am_op; op_b = am_op; neg_term = 1'b1; end
                    6'd17: begin op_a = bm_op; op_b = bm_op; neg_term = 1'b1; end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Shared multiplier: full product, floor shift, signed term.
    logic signed [2*CW-1:0] prod;
    logic signed [SW-1:0] term, sum;
    assign prod = op_a * op_b;
    always_comb begin
        if (sh29) begin
            term = SW'(prod >>> 29) <<< 1;
        end else begin
            term = SW'(prod >>> 30);
        end
        if (neg_term) begin
            term = -term;
        end
        sum = first_term ? term : acc_reg + term;
    end

    // Saturation helpers.
    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        begin
            if (v > SW'(32'sh7FFFFFFF)) begin
                return 32'sh7FFFFFFF;
            end else if (v < SW'(32'sh80000000)) begin
                return 32'sh80000000;
            end
            return v[31:0];
        end
    endfunction

    function automatic logic [17:0] to_out(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        begin
            r = (v + SW'(4096)) >>> 13;
            if (r > SW'(131071)) begin
                return 18'h1FFFF;
            end else if (r < -SW'(131072)) begin
                return 18'h20000;
            end
            return r[17:0];
        end
    endfunction

    // Sequencer: next state and step.
    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        cordic_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cordic_start = 1'b1;
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                if (cordic_done) begin
                    state_next = ST_DELTA;
                    step_next = '0;
                end
            end
            ST_DELTA: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 6'd11) begin
                    state_next = ST_HAM;
                    step_next = '0;
                end
            end
            ST_HAM: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 6'd15) begin
                    state_next = ST_MAT;
                    step_next = '0;
                end
            end
            ST_MAT: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 6'd17) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
        end else begin
            state_reg <= state_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg[0] <= ONE_Q29;
            q_reg[1] <= '0;
            q_reg[2] <= '0;
            q_reg[3] <= '0;
        end else begin
            acc_reg <= sum;
            unique case (state_reg)
                ST_DELTA: begin
                    if (step_reg < 6'd4) begin
                        t_reg[step_reg[1:0]] <= CW'(sum);
                    end else if (last_term) begin
                        d_reg[2'((step_reg - 6'd4) >> 1)] <= CW'(sum);
                    end
                end
                ST_HAM: begin
                    if (last_term) begin
                        nq_reg[dst[1:0]] <= sat32(sum);
                    end
                    if (step_reg == 6'd15) begin
                        q_reg[0] <= nq_reg[0];
                        q_reg[1] <= nq_reg[1];
                        q_reg[2] <= nq_reg[2];
                        q_reg[3] <= sat32(sum);
                    end
                end
                ST_MAT: begin
                    // Diagonal entries add the constant one.
                    if (last_term) begin
                        if (dst == 4'd0 || dst == 4'd4 || dst == 4'd8) begin
                            out_reg[dst] <= to_out(SW'(ONE_Q29) + sum);
                        end else begin
                            out_reg[dst] <= to_out(sum);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata = {6'd0, out_reg[8], out_reg[7], out_reg[6], out_reg[5], out_reg[4],
        out_reg[3], out_reg[2], out_reg[1], out_reg[0]};

    // An accepted request moves the sequencer to the CORDIC state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_CORDIC))
        else $error("request accepted but sequencer did not start");

    // A result held under stall keeps its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // Never ready while a result is pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("ready while result pending");

endmodule
